// ----- rtl/mrbm_pkg.sv -----
// ----------------------------------------------------------------------------
// mrbm_pkg
// Shared types and constants of the maximal rectangle core: field widths,
// saturation caps and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package mrbm_pkg;

  localparam int H_W    = 7;   // column height width
  localparam int AREA_W = 13;  // result area width
  localparam int CFG_W  = 7;   // cols_in_use width

  localparam logic [H_W-1:0]    HEIGHT_CAP = 7'd127;
  localparam logic [AREA_W-1:0] AREA_CAP   = 13'd8191;
  localparam logic [CFG_W-1:0]  COLS_RESET = 7'd64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture an input transaction, read its column height
    logic hgt_upd;  // update and write back the column height
    logic pop;      // pop the top bar and form its area product
    logic flush;    // right edge is one past the current column
    logic score;    // fold the registered product into the best area
    logic push;     // push (column, height)
    logic advance;  // step to the next column
    logic row_rst;  // row finished, back to column zero
    logic emit;     // load the result register and clear the matrix state
  } mrbm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pop_ok;   // stack not empty and top bar not lower than new height
    logic top_nz;   // stack not empty
    logic row_end;  // current column closes the row
    logic last;     // current cell is the last of the matrix
    logic out_full; // result register still holds an untaken result
  } mrbm_sts_t;

endpackage

// ----- rtl/mrbm_in_if.sv -----
// ----------------------------------------------------------------------------
// mrbm_in_if
// Cell input channel: one matrix cell per transaction.
// ----------------------------------------------------------------------------
interface mrbm_in_if;
  logic valid;
  logic ready;
  logic cell_bit;
  logic last_in_matrix;

  modport source (output valid, output cell_bit, output last_in_matrix, input ready);
  modport sink   (input valid, input cell_bit, input last_in_matrix, output ready);
endinterface

// ----- rtl/mrbm_out_if.sv -----
// ----------------------------------------------------------------------------
// mrbm_out_if
// Result channel: largest all-ones rectangle area of one matrix.
// ----------------------------------------------------------------------------
interface mrbm_out_if;
  logic                        valid;
  logic                        ready;
  logic [mrbm_pkg::AREA_W-1:0] max_area;

  modport source (output valid, output max_area, input ready);
  modport sink   (input valid, input max_area, output ready);
endinterface

// ----- rtl/mrbm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mrbm_cfg_if
// Configuration write channel for the row width register.
// ----------------------------------------------------------------------------
interface mrbm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mrbm_pkg::CFG_W-1:0] cols_in_use;

  modport source (output valid, output cols_in_use, input ready);
  modport sink   (input valid, input cols_in_use, output ready);
endinterface

// ----- rtl/mrbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrbm_ctrl
// Sequencer for one cell: height update, pop loop against the new bar,
// push, end-of-row flush and result emit.
// ----------------------------------------------------------------------------
module mrbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrbm_pkg::mrbm_sts_t sts,
  output mrbm_pkg::mrbm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_HGT     = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_SCORE_C = 3'd3;
  localparam logic [2:0] S_SETTLE  = 3'd4;
  localparam logic [2:0] S_FLUSH   = 3'd5;
  localparam logic [2:0] S_SCORE_F = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HGT;
        end
      end
      S_HGT: begin
        cmd.hgt_upd = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (sts.pop_ok) begin
          cmd.pop   = 1'b1;
          state_nxt = S_SCORE_C;
        end else begin
          cmd.push = 1'b1;
          if (sts.row_end || sts.last) begin
            state_nxt = S_SETTLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_SCORE_C: begin
        cmd.score = 1'b1;
        state_nxt = S_CMP;
      end
      // let the stack read catch up with the push
      S_SETTLE: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts.top_nz) begin
          cmd.pop   = 1'b1;
          cmd.flush = 1'b1;
          state_nxt = S_SCORE_F;
        end else begin
          cmd.row_rst = 1'b1;
          state_nxt   = sts.last ? S_EMIT : S_IDLE;
        end
      end
      S_SCORE_F: begin
        cmd.score = 1'b1;
        state_nxt = S_FLUSH;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mrbm_dpath.sv -----
// ----------------------------------------------------------------------------
// mrbm_dpath
// Column height memory with valid bits, stack memory with two read ports, area
// multiplier, best-area register, row width register and result register.
// ----------------------------------------------------------------------------
module mrbm_dpath #(
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mrbm_pkg::mrbm_cmd_t              cmd,
  output mrbm_pkg::mrbm_sts_t              sts,
  input  logic                             cell_bit,
  input  logic                             last_in_matrix,
  input  logic                             cfg_valid,
  input  logic [mrbm_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mrbm_pkg::AREA_W-1:0]      out_area
);

  localparam int H_W    = mrbm_pkg::H_W;
  localparam int AREA_W = mrbm_pkg::AREA_W;
  localparam int CFG_W  = mrbm_pkg::CFG_W;
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int IDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SDEPTH = MAX_COLS + 1;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int SP_W   = $clog2(SDEPTH + 1);
  localparam int EW     = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int PW     = H_W + COL_W;
  localparam int SW     = (PW > AREA_W) ? PW : AREA_W;

  // configuration
  logic [CFG_W-1:0] cols_r;

  // current cell
  logic             bit_r;
  logic             last_r;
  logic [IDX_W-1:0] pos_r;
  logic [COL_W-1:0] column_pos_r;
  logic [H_W-1:0]   h_r;

  // height memory
  logic [H_W-1:0]    hgt_mem [MAX_COLS];
  logic [MAX_COLS-1:0] hvalid_r;
  logic [H_W-1:0]    hrd_r;
  logic              hv_rd_r;

  // stack memory
  logic [H_W-1:0]   shgt_mem [SDEPTH];
  logic [IDX_W-1:0] sidx_mem [SDEPTH];
  logic [SP_W-1:0]  top_r;
  logic [H_W-1:0]   srd_h_r;
  logic [IDX_W-1:0] srd_i_r;

  // scoring
  logic [PW-1:0]     prod_r;
  logic [AREA_W-1:0] best_r;

  // result
  logic              out_valid_r;
  logic [AREA_W-1:0] out_area_r;

  logic [IDX_W-1:0]  pos_in;
  logic [COL_W-1:0]  pos_p1;
  logic [H_W-1:0]    h_cur;
  logic [H_W-1:0]    h_new;
  logic              top_nz;
  logic [SA_W-1:0]   ra_top;
  logic [SA_W-1:0]   ra_below;
  logic [COL_W-1:0]  left_edge;
  logic [COL_W-1:0]  right_edge;
  logic [COL_W-1:0]  span;
  logic [SW-1:0]     prod_ext;
  logic [AREA_W-1:0] area_sat;
  logic              row_end;

  assign pos_in = (column_pos_r >= COL_W'(MAX_COLS)) ? IDX_W'(MAX_COLS - 1)
                                                     : column_pos_r[IDX_W-1:0];
  assign pos_p1 = COL_W'(pos_r) + COL_W'(1);

  assign h_cur = hv_rd_r ? hrd_r : '0;
  always_comb begin
    if (!bit_r) begin
      h_new = '0;
    end else if (h_cur < mrbm_pkg::HEIGHT_CAP) begin
      h_new = h_cur + H_W'(1);
    end else begin
      h_new = mrbm_pkg::HEIGHT_CAP;
    end
  end

  assign top_nz   = (top_r != '0);
  assign ra_top   = top_nz ? SA_W'(top_r - SP_W'(1)) : '0;
  assign ra_below = (top_r >= SP_W'(2)) ? SA_W'(top_r - SP_W'(2)) : '0;

  // span of a popped bar: from just past the bar below it to the right edge
  assign left_edge  = (top_r == SP_W'(1)) ? '0 : COL_W'(srd_i_r) + COL_W'(1);
  assign right_edge = cmd.flush ? pos_p1 : COL_W'(pos_r);
  assign span       = (right_edge > left_edge) ? right_edge - left_edge : '0;

  assign prod_ext = SW'(prod_r);
  assign area_sat = (prod_ext > SW'(mrbm_pkg::AREA_CAP)) ? mrbm_pkg::AREA_CAP
                                                         : prod_ext[AREA_W-1:0];

  assign row_end = (cols_r == '0) || (pos_r == IDX_W'(MAX_COLS - 1)) ||
                   (EW'(pos_p1) >= EW'(cols_r));

  assign sts.pop_ok   = top_nz && (srd_h_r >= h_r);
  assign sts.top_nz   = top_nz;
  assign sts.row_end  = row_end;
  assign sts.last     = last_r;
  assign sts.out_full = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_area  = out_area_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r       <= mrbm_pkg::COLS_RESET;
      column_pos_r <= '0;
      hvalid_r     <= '0;
      top_r        <= '0;
      best_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cols_r <= cfg_data;
      end
      if (cmd.hgt_upd) begin
        hvalid_r[pos_r] <= 1'b1;
      end
      if (cmd.pop) begin
        top_r <= top_r - SP_W'(1);
      end else if (cmd.push && (top_r <= SP_W'(MAX_COLS))) begin
        top_r <= top_r + SP_W'(1);
      end
      if (cmd.advance) begin
        column_pos_r <= pos_p1;
      end else if (cmd.row_rst) begin
        column_pos_r <= '0;
      end
      if (cmd.score && (area_sat > best_r)) begin
        best_r <= area_sat;
      end
      if (cmd.emit) begin
        out_valid_r  <= 1'b1;
        best_r       <= '0;
        hvalid_r     <= '0;
        top_r        <= '0;
        column_pos_r <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bit_r   <= cell_bit;
      last_r  <= last_in_matrix;
      pos_r   <= pos_in;
      hrd_r   <= hgt_mem[pos_in];
      hv_rd_r <= hvalid_r[pos_in];
    end
    if (cmd.hgt_upd) begin
      h_r              <= h_new;
      hgt_mem[pos_r]   <= h_new;
    end
    if (cmd.pop) begin
      prod_r <= PW'(srd_h_r) * PW'(span);
    end
    if (cmd.emit) begin
      out_area_r <= best_r;
    end
  end

  // stack memory: one write port, two registered read ports at the top
  always_ff @(posedge clk) begin
    if (cmd.push && (top_r <= SP_W'(MAX_COLS))) begin
      shgt_mem[SA_W'(top_r)] <= h_r;
      sidx_mem[SA_W'(top_r)] <= pos_r;
    end
    srd_h_r <= shgt_mem[ra_top];
    srd_i_r <= sidx_mem[ra_below];
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= SP_W'(MAX_COLS))
    else $error("stack depth beyond row width");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> top_nz)
    else $error("pop from empty stack");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("result overwritten before taken");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (best_r == '0) && (top_r == '0) && (hvalid_r == '0))
    else $error("matrix state not cleared after result");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result raised without emit");
`endif

endmodule

// ----- rtl/max_rectangle_binary_matrix_core.sv -----
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix_core
// Largest all-ones rectangle of a binary matrix fed one cell per transaction
// in row-major order, using per-column heights and a monotonic stack.
//
//   channel   dir   payload                      handshake
//   in_ch     in    cell_bit, last_in_matrix     valid/ready
//   out_ch    out   max_area (13 b)              valid/ready
//   cfg_ch    in    cols_in_use (7 b)            valid/ready, always ready
//
// A cell is loaded and its height updated; each bar not lower than the new
// height is popped and scored, then the cell is pushed. A cell closing a row
// settles and flushes all bars left on the stack; the last cell then emits.
// Each column is pushed and popped once per row; stack reads are registered.
// Reset clears all control state at once; no clearing pass is needed.
// The result register lets the next cell in while a result waits; a new
// result waits in the emit step until out_ch has taken the previous one.
// ----------------------------------------------------------------------------
module max_rectangle_binary_matrix_core #(
  parameter int MAX_COLS = 64
) (
  input logic              clk,
  input logic              rst_n,
  mrbm_in_if.sink          in_ch,
  mrbm_out_if.source       out_ch,
  mrbm_cfg_if.sink         cfg_ch
);

  mrbm_pkg::mrbm_cmd_t cmd;
  mrbm_pkg::mrbm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  mrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrbm_dpath #(
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cell_bit       (in_ch.cell_bit),
    .last_in_matrix (in_ch.last_in_matrix),
    .cfg_valid      (cfg_ch.valid),
    .cfg_data       (cfg_ch.cols_in_use),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_area       (out_ch.max_area)
  );

endmodule
